[design/ldl_pkg.sv]
// shared types and constants for the ldl factorization block
// no dependencies
package ldl_pkg;
  localparam int MAX_ORDER_DEF   = 8;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_FACTOR = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_IDX  = 2'd3;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE, OP_MUL, OP_ADD, OP_SUB, OP_DIV
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
    logic sat;
  } dp_stat_t;
endpackage

[design/ldl_ram.sv]
// generic single-port ram with registered read
// no dependencies
module ldl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[design/ldl_datapath.sv]
// saturating fixed point arithmetic unit: multiply, add, subtract, divide
// depends on ldl_pkg
module ldl_datapath #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ldl_pkg::dp_cmd_t              cmd,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic signed [VALUE_WIDTH-1:0] y,
  output ldl_pkg::dp_stat_t             stat
);
  import ldl_pkg::*;
  localparam int W  = VALUE_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} st_t;
  st_t st;

  logic [W-1:0]    ma, mb;
  logic            neg;
  logic [2*W-1:0]  prod;
  logic [NW-1:0]   num;
  logic [W:0]      rem;
  logic [NW-1:0]   quo;
  logic [CW-1:0]   cnt;
  logic [NW-1:0]   mag;

  logic [W-1:0]    abs_a, abs_b;
  logic signed [W:0] sum;
  logic [W:0]      rsh, rsub;
  logic            lim_ok;
  logic [NW-1:0]   mul_mag;

  assign abs_a = a[W-1] ? W'(-a) : W'(a);
  assign abs_b = b[W-1] ? W'(-b) : W'(b);
  assign sum = (cmd.op == OP_SUB) ? ({a[W-1], a} - {b[W-1], b})
                                  : ({a[W-1], a} + {b[W-1], b});
  assign rsh  = {rem[W-1:0], num[NW-1]};
  assign rsub = rsh - {1'b0, mb};
  assign mul_mag = NW'(prod >> FRAC_BITS);
  assign lim_ok = (mag <= NW'({1'b0, VMAX}) + NW'(neg));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      case (st)
        S_IDLE: if (cmd.start) begin
          neg <= a[W-1] ^ b[W-1];
          ma <= abs_a;
          mb <= abs_b;
          stat.zero <= (b == '0);
          case (cmd.op)
            OP_MUL: st <= S_MUL;
            OP_DIV: begin
              num <= {abs_a, {FRAC_BITS{1'b0}}};
              rem <= '0;
              quo <= '0;
              cnt <= CW'(NW);
              st <= S_DIV;
            end
            default: begin
              stat.done <= 1'b1;
              stat.sat <= (sum[W] != sum[W-1]);
              y <= (sum[W] != sum[W-1]) ? (sum[W] ? VMIN : VMAX) : sum[W-1:0];
            end
          endcase
        end
        S_MUL: begin
          prod <= ma * mb;
          st <= S_FIN;
          cnt <= '0;
        end
        S_DIV: begin
          num <= num << 1;
          if (rsh >= {1'b0, mb}) begin
            rem <= rsub;
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[NW-2:0], 1'b0};
          end
          if (cnt == CW'(1)) begin
            // last quotient bit goes straight into the magnitude
            mag <= {quo[NW-2:0], (rsh >= {1'b0, mb})};
            cnt <= CW'(1);
            st <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          // cnt zero marks the product path, which first scales the product into the magnitude
          if (cnt == '0 && prod != '1) begin
            mag <= (|(prod >> (FRAC_BITS + NW))) ? '1 : mul_mag;
            cnt <= CW'(1);
          end else begin
            stat.done <= 1'b1;
            st <= S_IDLE;
            if (!lim_ok) begin
              stat.sat <= 1'b1;
              y <= neg ? VMIN : VMAX;
            end else begin
              stat.sat <= 1'b0;
              y <= neg ? W'(-mag) : W'(mag);
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

[design/ldl_ctrl.sv]
// sequencer for commands and the factorization loops
// depends on ldl_pkg, ldl_ram, ldl_datapath
module ldl_ctrl #(
  parameter int MAX_ORDER   = 8,
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  order_cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]  status
);
  import ldl_pkg::*;
  localparam int W  = VALUE_WIDTH;
  localparam int IW = $clog2(MAX_ORDER);
  localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    IDLE, RD_WAIT, RD_OUT, F_J, F_PI_RD, F_PI_MUL, F_SUM_RD, F_SUM_MUL,
    F_SUM_ADD, F_FIN_RD, F_FIN_SUB, F_DIV, F_WR, DONE
  } st_t;
  st_t st;

  logic [IW:0] n, j, i, k;
  logic diag;
  logic zpiv, sath;
  logic signed [W-1:0] ts, tmp;
  logic [W-1:0] piv [MAX_ORDER];

  logic we;
  logic [AW-1:0] addr;
  logic [W-1:0] wdata, rdata;
  dp_cmd_t dcmd;
  dp_stat_t dst;
  logic signed [W-1:0] da, db, dy;

  logic [IW:0] n_eff;
  assign n_eff = (order_cfg == 4'd0) ? (IW+1)'(1) :
                 (32'(order_cfg) > MAX_ORDER) ? (IW+1)'(MAX_ORDER) : (IW+1)'(order_cfg);

  function automatic logic [AW-1:0] el(input logic [IW:0] r, input logic [IW:0] c);
    el = AW'(r[IW-1:0]) * AW'(MAX_ORDER) + AW'(c[IW-1:0]);
  endfunction

  ldl_ram #(.WIDTH(W), .DEPTH(MAX_ORDER * MAX_ORDER)) u_ram (
    .clk, .we, .addr, .wdata, .rdata
  );
  ldl_datapath #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd(dcmd), .a(da), .b(db), .y(dy), .stat(dst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
      out_valid <= 1'b0;
      we <= 1'b0;
      dcmd <= '0;
    end else begin
      we <= 1'b0;
      dcmd.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        IDLE: if (in_valid && in_ready) begin
          read_value <= '0;
          status <= ST_OK;
          if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            if (32'(row) >= 32'(n_eff) || 32'(col) >= 32'(n_eff)) begin
              status <= ST_IDX;
              out_valid <= 1'b1;
            end else if (cmd == CMD_WRITE) begin
              we <= 1'b1;
              addr <= el((IW+1)'(row), (IW+1)'(col));
              if (W >= 32) wdata <= W'(value);
              else if (value > 32'(VMAX)) begin
                wdata <= VMAX; status <= ST_SAT;
              end else if (value < 32'(VMIN)) begin
                wdata <= VMIN; status <= ST_SAT;
              end else wdata <= W'(value);
              out_valid <= 1'b1;
            end else begin
              addr <= el((IW+1)'(row), (IW+1)'(col));
              st <= RD_WAIT;
            end
          end else if (cmd == CMD_FACTOR) begin
            n <= n_eff; j <= '0; zpiv <= 1'b0; sath <= 1'b0;
            st <= F_J;
          end else out_valid <= 1'b1;
        end
        RD_WAIT: st <= RD_OUT;
        RD_OUT: begin
          if (W > 32 && $signed(rdata) > $signed(64'sh7fffffff)) begin
            read_value <= 32'sh7fffffff; status <= ST_SAT;
          end else if (W > 32 && $signed(rdata) < -$signed(64'sh80000000)) begin
            read_value <= 32'sh80000000; status <= ST_SAT;
          end else read_value <= 32'($signed(rdata));
          out_valid <= 1'b1;
          st <= IDLE;
        end
        F_J: begin
          if (j == n) st <= DONE;
          else begin i <= '0; st <= F_PI_RD; addr <= el('0, '0); end
        end
        // pivot_work[i] = D(i) * L(j,i)
        F_PI_RD: begin
          if (i == j) begin
            i <= j; k <= '0; ts <= '0; diag <= 1'b1; st <= F_SUM_RD;
          end else begin
            addr <= el(i, i); tmp <= '0; st <= F_PI_MUL; k <= '0;
          end
        end
        F_PI_MUL: begin
          k <= k + 1'b1;
          if (k == 1) begin tmp <= rdata; addr <= el(j, i); end
          if (k == 3) begin
            da <= tmp; db <= rdata; dcmd <= '{1'b1, OP_MUL};
          end
          if (k > 3 && dst.done) begin
            piv[i[IW-1:0]] <= dy; sath <= sath | dst.sat;
            i <= i + 1'b1; st <= F_PI_RD;
          end
        end
        // ts = sum over k of EL(i,k) * pivot_work[k]
        F_SUM_RD: begin
          if (k == j) begin addr <= el(i, j); tmp <= '0; st <= F_FIN_RD; end
          else begin addr <= el(i, k); tmp <= '0; st <= F_SUM_MUL; end
        end
        F_SUM_MUL: begin
          tmp <= tmp + 1'b1;
          if (tmp == 1) begin da <= rdata; db <= piv[k[IW-1:0]]; dcmd <= '{1'b1, OP_MUL}; end
          if (tmp > 1 && dst.done) begin
            sath <= sath | dst.sat;
            da <= ts; db <= dy; dcmd <= '{1'b1, OP_ADD};
            st <= F_SUM_ADD;
          end
        end
        F_SUM_ADD: if (dst.done) begin
          sath <= sath | dst.sat; ts <= dy; k <= k + 1'b1; st <= F_SUM_RD;
        end
        F_FIN_RD: begin
          tmp <= tmp + 1'b1;
          if (tmp == 1) begin
            da <= rdata; db <= ts; dcmd <= '{1'b1, OP_SUB}; st <= F_FIN_SUB;
          end
        end
        F_FIN_SUB: if (dst.done) begin
          sath <= sath | dst.sat;
          if (diag) begin
            piv[j[IW-1:0]] <= dy; wdata <= dy;
            if (dy == '0) zpiv <= 1'b1;
            st <= F_WR;
          end else if (piv[j[IW-1:0]] == '0) begin
            wdata <= '0; st <= F_WR;
          end else begin
            da <= dy; db <= piv[j[IW-1:0]]; dcmd <= '{1'b1, OP_DIV}; st <= F_DIV;
          end
        end
        F_DIV: if (dst.done) begin
          sath <= sath | dst.sat; wdata <= dy; st <= F_WR;
        end
        F_WR: begin
          we <= 1'b1; addr <= el(i, j);
          diag <= 1'b0; k <= '0; ts <= '0;
          if (i + 1'b1 >= n) begin j <= j + 1'b1; st <= F_J; end
          else begin i <= i + 1'b1; st <= F_SUM_RD; end
        end
        DONE: begin
          status <= zpiv ? ST_ZERO : (sath ? ST_SAT : ST_OK);
          read_value <= '0;
          out_valid <= 1'b1;
          st <= IDLE;
        end
        default: st <= IDLE;
      endcase
    end
  end

  assign in_ready = (st == IDLE) && !out_valid;
endmodule

[design/ldl_factorization.sv]
// top level of the ldl factorization block
// depends on ldl_pkg and ldl_ctrl (which holds the ram and the arithmetic unit)
//
// an item is a command: write element, factor, or read element. a read goes
// through a registered ram read. factor walks the active order n one ram
// access and one arithmetic operation at a time: about n^3/6
// multiply-accumulate steps and n^2/2 pivot products, plus, per lower
// element, a subtract, a bit-serial divide when the pivot is nonzero and a
// write back. the single ram port and the shared arithmetic unit serialize
// this work.
module ldl_factorization #(
  parameter int MAX_ORDER   = ldl_pkg::MAX_ORDER_DEF,
  parameter int VALUE_WIDTH = ldl_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = ldl_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,     // active_order
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,       // cmd[1:0] row[4:2] col[7:5] value[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata        // read_value[31:0] status[33:32], zero fill
);
  import ldl_pkg::*;
  logic [3:0] order;
  logic [31:0] rv;
  logic [1:0]  st;

  // active order register, reset to 8
  always_ff @(posedge clk) begin
    if (rst) order <= 4'd8;
    else if (cfg_we) order <= cfg_wdata;
  end

  ldl_ctrl #(.MAX_ORDER(MAX_ORDER), .VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk, .rst, .order_cfg(order),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .cmd(s_tdata[1:0]), .row(s_tdata[4:2]), .col(s_tdata[7:5]),
    .value(s_tdata[39:8]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .read_value(rv), .status(st)
  );

  assign m_tdata = {6'd0, st, rv};

`ifndef SYNTHESIS
  // no new item is taken while a result waits
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("item accepted with result pending");
  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while stalled");
`endif
endmodule
